// ===== rtl/utd_pkg.sv =====
package utd_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned AccW   = 31;
   localparam int unsigned GrpW   = 32;
   localparam int unsigned CountW = 3;

   localparam logic [CountW-1:0] EmitTwo   = 3'd2;
   localparam logic [CountW-1:0] EmitThree = 3'd3;
   localparam logic [CountW-1:0] EmitFour  = 3'd4;
   localparam logic [CountW-1:0] EmitErr   = 3'd1;
   localparam logic [CountW-1:0] MaxLeft   = 3'd5;

   typedef struct packed {
      logic [AccW-1:0]   accum;
      logic [CountW-1:0] left;
      logic [CountW-1:0] emit;
   } utd_state_type;

   // one decoded result group: up to four big-endian bytes
   typedef struct packed {
      logic              valid;
      logic              bad;
      logic [CountW-1:0] cnt;
      logic [GrpW-1:0]   data;
   } utd_grp_type;

endpackage

// ===== rtl/utf8_to_ucs_byte_decoder.sv =====
// UTF-8 to big-endian UCS byte decoder. One UTF-8 byte enters per word; a completed
// sequence leaves as 2, 3 or 4 code point bytes, most significant first, with tlast on
// the final byte. A bad lead byte, or a string ending mid-sequence, gives a single zero
// byte with tuser set and the decoder starts afresh. Input and output each move one
// word per cycle unless held by rsp_tready back-pressure: continuation bytes that end
// no sequence are taken every cycle, while a completed item waits at the input until
// the last byte of the previous group leaves. A word passes through the input register,
// then the result register, on its way to the output.
module utf8_to_ucs_byte_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // last_in
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // run_last
   output logic       rsp_tuser    // bad_seq
);
   import utd_pkg::*;

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff, in_byte_in;
   logic          in_last_ff, in_last_in;
   utd_state_type st_ff, st_in, st_nxt;
   utd_grp_type   dec_grp;
   logic          grp_valid_ff, grp_valid_in;
   logic          bad_ff, bad_in;
   logic [CountW-1:0] rem_ff, rem_in;
   logic [GrpW-1:0]   data_ff, data_in;
   logic          out_go, grp_free, in_go, req_go;
   logic [1:0]    sel;

   utd_decode u_decode (
      .in_byte (in_byte_ff),
      .last_in (in_last_ff),
      .cur     (st_ff),
      .nxt     (st_nxt),
      .grp     (dec_grp)
   );

   assign out_go     = rsp_tvalid && rsp_tready;
   assign grp_free   = !grp_valid_ff || (out_go && rem_ff == 3'd1);
   assign in_go      = in_valid_ff && (grp_free || !dec_grp.valid);
   assign req_tready = !in_valid_ff || in_go;
   assign req_go     = req_tvalid && req_tready;

   assign sel        = rem_ff[1:0] - 2'd1;
   assign rsp_tvalid = grp_valid_ff;
   assign rsp_tdata  = data_ff[sel*ByteW +: ByteW];
   assign rsp_tlast  = rem_ff == 3'd1;
   assign rsp_tuser  = bad_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (in_go) begin
         in_valid_in = 1'b0;
      end
      if (req_go) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end
   end

   always_comb begin
      st_in        = in_go ? st_nxt : st_ff;
      grp_valid_in = grp_valid_ff;
      rem_in       = rem_ff;
      bad_in       = bad_ff;
      data_in      = data_ff;
      if (out_go) begin
         rem_in = rem_ff - 3'd1;
         if (rem_ff == 3'd1) begin
            grp_valid_in = 1'b0;
         end
      end
      if (in_go && dec_grp.valid) begin
         grp_valid_in = 1'b1;
         rem_in       = dec_grp.cnt;
         bad_in       = dec_grp.bad;
         data_in      = dec_grp.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         grp_valid_ff <= 1'b0;
         st_ff        <= '0;
         rem_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         grp_valid_ff <= grp_valid_in;
         st_ff        <= st_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      bad_ff     <= bad_in;
      data_ff    <= data_in;
   end

`ifndef NO_ASSERTIONS
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      grp_valid_ff |-> (rem_ff != 3'd0 && rem_ff <= EmitFour))
      else $error("result group with bad byte count");

   a_bad_single: assert property (@(posedge clock) disable iff (reset)
      (grp_valid_ff && bad_ff) |-> rem_ff == 3'd1)
      else $error("error result longer than one word");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      st_ff.left <= MaxLeft)
      else $error("continuation count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (grp_valid_ff && !out_go) |=> ($stable(data_ff) && $stable(rem_ff)))
      else $error("pending result group overwritten");
`endif

endmodule

// ===== rtl/utd_decode.sv =====
module utd_decode (
   input  logic [7:0]             in_byte,
   input  logic                   last_in,
   input  utd_pkg::utd_state_type cur,
   output utd_pkg::utd_state_type nxt,
   output utd_pkg::utd_grp_type   grp
);
   import utd_pkg::*;

   utd_grp_type   err_grp;
   utd_state_type clr;
   logic [AccW-1:0]   shifted;
   logic [CountW-1:0] left_dec;

   assign err_grp  = '{valid: 1'b1, bad: 1'b1, cnt: EmitErr, data: '0};
   assign clr      = '0;
   assign shifted  = {cur.accum[AccW-7:0], in_byte[5:0]};
   assign left_dec = cur.left - 3'd1;

   always_comb begin
      nxt = cur;
      grp = '0;
      if (cur.left == '0) begin
         case (in_byte) inside
            8'b0???????: begin
               grp = '{valid: 1'b1, bad: 1'b0, cnt: EmitTwo,
                       data: {{(GrpW-ByteW){1'b0}}, in_byte}};
               nxt = clr;
            end
            8'b110?????: nxt = '{accum: AccW'(in_byte[4:0]), left: 3'd1, emit: EmitTwo};
            8'b1110????: nxt = '{accum: AccW'(in_byte[3:0]), left: 3'd2, emit: EmitTwo};
            8'b11110???: nxt = '{accum: AccW'(in_byte[2:0]), left: 3'd3, emit: EmitThree};
            8'b111110??: nxt = '{accum: AccW'(in_byte[1:0]), left: 3'd4, emit: EmitFour};
            8'b1111110?: nxt = '{accum: AccW'(in_byte[0]),   left: 3'd5, emit: EmitFour};
            default: begin
               grp = err_grp;
               nxt = clr;
            end
         endcase
         if (!in_byte[7] == 1'b0 && last_in) begin
            grp = err_grp;
            nxt = clr;
         end
      end else begin
         nxt.accum = shifted;
         nxt.left  = left_dec;
         if (left_dec != '0) begin
            if (last_in) begin
               grp = err_grp;
               nxt = clr;
            end
         end else begin
            grp.valid = 1'b1;
            grp.bad   = 1'b0;
            grp.data  = {1'b0, shifted};
            grp.cnt   = (cur.emit == EmitThree || cur.emit == EmitFour) ? cur.emit : EmitTwo;
            nxt       = clr;
         end
      end
   end

endmodule
